/* hw/rtl/mtma_pkg.sv */
// Shared types for the median-then-moving-average filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mtma_pkg;

  localparam int SAMPLE_W = 12;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Broadcast from the window chain to every rank cell
  typedef struct packed {
    logic    shift;   // a new sample enters, the oldest leaves
    sample_t fresh;   // sample entering at the head
    sample_t oldest;  // sample leaving at the tail
  } bcast_t;

  // Control from the top level to the averaging stage
  typedef struct packed {
    logic load;   // push a median into the ring and update the sum
    logic scale;  // register the scaled sum for the output
  } avg_ctl_t;

endpackage

/* hw/rtl/mtma_rank_cell.sv */
// One cell of the sliding window: holds a sample and its rank in the window.
// Depends on mtma_pkg.
`timescale 1ns / 1ps

module mtma_rank_cell #(
  parameter int                RANK_W     = 3,
  parameter logic [RANK_W-1:0] RESET_RANK = '0
) (
  input  logic                clk,
  input  logic                rst,
  input  mtma_pkg::bcast_t    bus,
  input  mtma_pkg::sample_t   in_value,
  input  logic [RANK_W-1:0]   in_rank,
  output mtma_pkg::sample_t   value,
  output logic [RANK_W-1:0]   rank,
  output logic [RANK_W-1:0]   fwd_rank,
  output logic                le_fresh
);

  // Ties rank by age: the leaving sample sits below any equal value,
  // the fresh sample above any equal value.
  assign fwd_rank = rank - RANK_W'(bus.oldest <= value) + RANK_W'(bus.fresh < value);
  assign le_fresh = (value <= bus.fresh);

  // Advance one place down the chain on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      rank  <= RESET_RANK;
    end else if (bus.shift) begin
      value <= in_value;
      rank  <= in_rank;
    end
  end

endmodule

/* hw/rtl/mtma_median_chain.sv */
// Row of rank cells forming the raw sample window, with median pick-off.
// Depends on mtma_pkg and mtma_rank_cell.
`timescale 1ns / 1ps

module mtma_median_chain #(
  parameter int MEDIAN_LEN = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  mtma_pkg::sample_t       sample,
  output mtma_pkg::sample_t       median,
  output logic [MEDIAN_LEN-1:0]   hit
);

  localparam int RANK_W = $clog2(MEDIAN_LEN);
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(MEDIAN_LEN / 2);

  mtma_pkg::bcast_t  bus;
  mtma_pkg::sample_t values   [MEDIAN_LEN];
  logic [RANK_W-1:0] ranks    [MEDIAN_LEN];
  logic [RANK_W-1:0] fwd      [MEDIAN_LEN];
  logic [MEDIAN_LEN-1:0] le_fresh;
  logic [RANK_W-1:0] head_rank;
  mtma_pkg::sample_t pick;

  assign bus.shift  = shift;
  assign bus.fresh  = sample;
  assign bus.oldest = values[MEDIAN_LEN-1];

  // Rank of the fresh sample: cells staying in the window at or below it
  always_comb begin
    head_rank = '0;
    for (int i = 0; i < MEDIAN_LEN - 1; i++) begin
      head_rank = head_rank + RANK_W'(le_fresh[i]);
    end
  end

  // Cell 0 holds the newest sample, the last cell the oldest
  for (genvar g = 0; g < MEDIAN_LEN; g++) begin : g_cell
    mtma_rank_cell #(
      .RANK_W     (RANK_W),
      .RESET_RANK (RANK_W'(MEDIAN_LEN - 1 - g))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bus      (bus),
      .in_value ((g == 0) ? sample : values[(g == 0) ? 0 : g - 1]),
      .in_rank  ((g == 0) ? head_rank : fwd[(g == 0) ? 0 : g - 1]),
      .value    (values[g]),
      .rank     (ranks[g]),
      .fwd_rank (fwd[g]),
      .le_fresh (le_fresh[g])
    );
    assign hit[g] = (ranks[g] == MID_RANK);
  end

  // Exactly one cell holds the middle rank; gate and merge
  always_comb begin
    pick = '0;
    for (int i = 0; i < MEDIAN_LEN; i++) begin
      pick = pick | (values[i] & {mtma_pkg::SAMPLE_W{hit[i]}});
    end
  end

  assign median = pick;

endmodule

/* hw/rtl/mtma_average.sv */
// Ring of recent medians, running sum and exact division by the ring length.
// Depends on mtma_pkg.
`timescale 1ns / 1ps

module mtma_average #(
  parameter int AVERAGE_LEN = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  mtma_pkg::avg_ctl_t  ctl,
  input  mtma_pkg::sample_t   median,
  output mtma_pkg::sample_t   filtered
);

  localparam int LOG_LEN = $clog2(AVERAGE_LEN);
  localparam int SUM_W   = mtma_pkg::SAMPLE_W + LOG_LEN;
  // Reciprocal scaling: exact for every sum below 2**SUM_W
  localparam int SHIFT   = SUM_W + LOG_LEN;
  localparam int RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(AVERAGE_LEN) - 64'd1) / 64'(AVERAGE_LEN));
  localparam int PROD_W  = SUM_W + RECIP_W;

  mtma_pkg::sample_t    ring [AVERAGE_LEN];
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;

  // Shift the ring, drop the oldest median from the sum, add the new one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVERAGE_LEN; i++) begin
        ring[i] <= '0;
      end
      sum <= '0;
    end else if (ctl.load) begin
      ring[0] <= median;
      for (int i = 1; i < AVERAGE_LEN; i++) begin
        ring[i] <= ring[i-1];
      end
      sum <= sum - SUM_W'(ring[AVERAGE_LEN-1]) + SUM_W'(median);
    end
  end

  // Scale the sum by the reciprocal of the ring length
  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      prod <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

  assign filtered = prod[SHIFT +: mtma_pkg::SAMPLE_W];

endmodule

/* hw/rtl/median_then_moving_average_unit.sv */
// Top level of the median-then-moving-average filter.
// Depends on mtma_pkg, mtma_median_chain and mtma_average.
//
// Usage:
//   One 12-bit ADC sample per beat on sample / sample_valid / sample_ready;
//   one filtered value per beat on filtered / filtered_valid / filtered_ready.
//   Each sample enters a window of MEDIAN_LEN samples kept as a row of rank
//   cells; the cell holding the middle rank gives the median, which enters a
//   ring of AVERAGE_LEN medians with a running sum. The output is that sum
//   divided by AVERAGE_LEN, truncated.
//   Path: the sample beat updates the window, then the ring and sum update,
//   then the reciprocal multiply is registered and filtered_valid rises;
//   each step waits while the stage after it is held. Throughput: one beat
//   per cycle while the output is not stalled; the cell row updates every
//   rank as each beat enters. Stalls: each stage holds its beat while the
//   next is full and cannot advance; sample_ready drops only when all three
//   stages are full and filtered_ready is low.
//   Reset: window, ring and sum clear to zero, so the first outputs include
//   those zeros; all stages empty.
`timescale 1ns / 1ps

module median_then_moving_average_unit #(
  parameter int MEDIAN_LEN  = 5,
  parameter int AVERAGE_LEN = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  mtma_pkg::sample_t   sample,
  input  logic                sample_valid,
  output logic                sample_ready,
  output mtma_pkg::sample_t   filtered,
  output logic                filtered_valid,
  input  logic                filtered_ready
);

  logic                  v1;
  logic                  v2;
  logic                  take;
  logic                  m2;
  logic                  m3;
  logic                  give;
  mtma_pkg::sample_t     median;
  logic [MEDIAN_LEN-1:0] hit;
  mtma_pkg::avg_ctl_t    ctl;

  // Stage moves: collapse bubbles, hold when the next stage is stalled
  assign give         = filtered_valid & filtered_ready;
  assign m3           = v2 & (~filtered_valid | filtered_ready);
  assign m2           = v1 & (~v2 | m3);
  assign sample_ready = ~v1 | m2;
  assign take         = sample_valid & sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      filtered_valid <= 1'b0;
    end else begin
      if (take) begin
        v1 <= 1'b1;
      end else if (m2) begin
        v1 <= 1'b0;
      end
      if (m2) begin
        v2 <= 1'b1;
      end else if (m3) begin
        v2 <= 1'b0;
      end
      if (m3) begin
        filtered_valid <= 1'b1;
      end else if (give) begin
        filtered_valid <= 1'b0;
      end
    end
  end

  mtma_median_chain #(
    .MEDIAN_LEN (MEDIAN_LEN)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .shift  (take),
    .sample (sample),
    .median (median),
    .hit    (hit)
  );

  assign ctl.load  = m2;
  assign ctl.scale = m3;

  mtma_average #(
    .AVERAGE_LEN (AVERAGE_LEN)
  ) u_average (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .median   (median),
    .filtered (filtered)
  );

  // Ranks stay a permutation: exactly one cell holds the middle rank
  a_one_median: assert property (@(posedge clk) disable iff (rst) $onehot(hit))
    else $error("median rank not held by exactly one cell");

  // Input back-pressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (v1 && v2 && filtered_valid && !filtered_ready))
    else $error("input stalled with room in the pipeline");

  // A beat in the window stage with the next stage free moves on
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v1 && !v2) |=> v2)
    else $error("window stage failed to advance");

endmodule

/* bench/tb.sv */
// Self-checking bench for median_then_moving_average_unit.
// Depends on mtma_pkg and the filter RTL; predicts every filtered value itself.
`timescale 1ns / 1ps

module tb;

  localparam int MEDIAN_LEN  = 5;
  localparam int AVERAGE_LEN = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    mtma_pkg::sample_t value;
    bit                drain_first;  // wait for every filtered value before sending
  } sample_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  mtma_pkg::sample_t sample = '0;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  mtma_pkg::sample_t filtered;
  logic              filtered_valid;
  logic              filtered_ready = 1'b0;

  sample_beat_t      pending_samples[$];
  mtma_pkg::sample_t expected_filtered[$];

  // Filter state mirrored from the block
  mtma_pkg::sample_t raw_hist [MEDIAN_LEN];
  int                raw_pos = 0;
  mtma_pkg::sample_t med_hist [AVERAGE_LEN];
  int                med_pos = 0;
  int                med_sum = 0;

  int sent_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;

  median_then_moving_average_unit #(
    .MEDIAN_LEN (MEDIAN_LEN),
    .AVERAGE_LEN(AVERAGE_LEN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .filtered      (filtered),
    .filtered_valid(filtered_valid),
    .filtered_ready(filtered_ready)
  );

  always #6 clk = ~clk;

  // Push one sample through the window median and the moving average
  function automatic mtma_pkg::sample_t filter_sample(mtma_pkg::sample_t value);
    mtma_pkg::sample_t sorted [MEDIAN_LEN];
    mtma_pkg::sample_t pick;
    mtma_pkg::sample_t median;
    int                k;
    raw_hist[raw_pos] = value;
    raw_pos = (raw_pos + 1) % MEDIAN_LEN;
    sorted = raw_hist;
    for (int i = 1; i < MEDIAN_LEN; i++) begin
      pick = sorted[i];
      k = i;
      while (k > 0 && sorted[k-1] > pick) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = pick;
    end
    median = sorted[MEDIAN_LEN/2];
    med_sum = med_sum - int'(med_hist[med_pos]) + int'(median);
    med_hist[med_pos] = median;
    med_pos = (med_pos + 1) % AVERAGE_LEN;
    return mtma_pkg::sample_t'(med_sum / AVERAGE_LEN);
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic mtma_pkg::sample_t clamp12(int value);
    if (value < 0) return '0;
    if (value > 4095) return 12'hFFF;
    return mtma_pkg::sample_t'(value);
  endfunction

  task automatic queue_sample(mtma_pkg::sample_t value, bit drain_first);
    sample_beat_t beat;
    beat.value = value;
    beat.drain_first = drain_first;
    pending_samples.push_back(beat);
  endtask

  // Driver: predict on each accepted beat, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        expected_filtered.push_back(filter_sample(sample));
        sent_count++;
      end
      if (!sample_valid || sample_ready) begin
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 299) == 0) send_calm = $urandom_range(50, 200);
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0 &&
                     !(pending_samples[0].drain_first && expected_filtered.size() > 0)) begin
          sample <= pending_samples[0].value;
          sample_valid <= 1'b1;
          void'(pending_samples.pop_front());
          send_gap = (send_calm > 0) ? 0 : draw_gap();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each filtered beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      filtered_ready <= 1'b0;
    end else begin
      if (filtered_valid && filtered_ready) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: unexpected filtered beat, expected none, actual %0d",
                   $time, filtered);
          error_count++;
        end else begin
          if (filtered !== expected_filtered[0]) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, expected_filtered[0], filtered);
            error_count++;
          end
          void'(expected_filtered.pop_front());
          checked_count++;
        end
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 299) == 0) recv_calm = $urandom_range(50, 200);
      if (recv_hold > 0) begin
        recv_hold--;
        filtered_ready <= 1'b0;
      end else if (recv_calm == 0 && $urandom_range(0, 5) == 0) begin
        recv_hold = draw_gap();
        filtered_ready <= (recv_hold == 0);
      end else begin
        filtered_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (filtered_valid && filtered_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int kind;
    int run_len;
    int level;
    int level_b;
    int slope;
    int queued;
    int next_drain;

    for (int i = 0; i < MEDIAN_LEN; i++) raw_hist[i] = '0;
    for (int i = 0; i < AVERAGE_LEN; i++) med_hist[i] = '0;

    // Rise from the cleared windows to full scale, wrapping the median window
    for (int i = 0; i < 6; i++) queue_sample(12'hFFF, 1'b0);
    // Lone dip that the median rejects
    queue_sample(12'h000, 1'b0);
    for (int i = 0; i < 3; i++) queue_sample(12'hFFF, 1'b0);
    // Majority flips to zero, the median follows
    for (int i = 0; i < 3; i++) queue_sample(12'h000, 1'b0);
    for (int i = 0; i < 2; i++) queue_sample(12'hFFF, 1'b0);
    queue_sample(12'd2048, 1'b0);
    queue_sample(12'd1, 1'b0);
    queue_sample(12'd4094, 1'b0);
    queue_sample(12'd2047, 1'b0);
    queue_sample(12'hFFF, 1'b0);
    queue_sample(12'h000, 1'b0);

    // Random part in shaped runs, with a drain now and then
    queued = 0;
    next_drain = 0;
    while (queued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 3);
      run_len = $urandom_range(5, 30);
      level = $urandom_range(0, 4095);
      level_b = $urandom_range(0, 4095);
      slope = $urandom_range(0, 80) - 40;
      for (int i = 0; i < run_len; i++) begin
        mtma_pkg::sample_t value;
        case (kind)
          0: begin
            value = $urandom_range(0, 4095);
          end
          1: begin
            value = clamp12(level + slope * i + $urandom_range(0, 32) - 16);
          end
          2: begin
            if ($urandom_range(0, 4) == 0)
              value = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
            else
              value = clamp12(level + $urandom_range(0, 8) - 4);
          end
          default: begin
            value = ((i / (1 + run_len / 4)) % 2 == 1) ? mtma_pkg::sample_t'(level_b)
                                                       : mtma_pkg::sample_t'(level);
          end
        endcase
        queue_sample(value, queued == next_drain);
        if (queued == next_drain) next_drain = queued + $urandom_range(200, 400);
        queued++;
      end
    end

    // Hold reset, then release it on a clock edge
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every sample has been accepted and checked
    while (pending_samples.size() > 0 || sample_valid) @(posedge clk);
    while (expected_filtered.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d filtered values checked, %0d mismatches",
             sent_count, checked_count, error_count);
    $display("covered start-up from zero, spikes, steps, ramps, noise and two-sided stalls");
    if (error_count == 0 && expected_filtered.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
